// ----- sv/chte_pkg.sv -----
package chte_pkg;

  localparam int Buckets    = 16;
  localparam int Entries    = 64;
  localparam int KeyBytes   = 8;
  localparam int ValueBits  = 32;
  localparam int BktW       = $clog2(Buckets);
  localparam int IdxW       = $clog2(Entries);
  localparam int PtrW       = IdxW + 1;
  localparam int CntW       = 7;
  localparam int QDepth     = 2;

  localparam logic [PtrW-1:0] NullPtr = PtrW'(Entries);

  typedef enum logic [1:0] {
    ACT_ADD     = 2'd0,
    ACT_REPLACE = 2'd1,
    ACT_LOOKUP  = 2'd2,
    ACT_REMOVE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_BAD  = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]     action;
    logic [63:0]    key;
    logic [3:0]     len;
    logic [31:0]    value;
    logic [31:0]    hash;
    logic           bad;
  } req_t;

  function automatic logic [63:0] key_mask(input logic [3:0] len);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < KeyBytes; i++) begin
      if (4'(i) < len) m[8*i +: 8] = 8'hff;
    end
    return m;
  endfunction

endpackage

// ----- sv/chained_hash_table_engine_top.sv -----
// channel  | ports                                              | handshake
// request  | in_action in_key_bytes in_key_length in_new_value  | start & !busy
// result   | out_status out_found_value out_entry_count         | out_valid, one cycle
// The front end hashes one key byte per cycle (up to 8), then the back end walks
// the chain through its entry memory, reading (B_RD) and comparing (B_CMP) each entry.
// Synchronous active-low reset empties all buckets; entry contents stay undefined.
// The receiver cannot stall; busy is high while hashing or waiting for queue space.
module chained_hash_table_engine_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [63:0] in_key_bytes,
  input  logic [3:0]  in_key_length,
  input  logic [31:0] in_new_value,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [31:0] out_found_value,
  output logic [6:0]  out_entry_count
);
  import chte_pkg::*;

  logic q_valid, q_pop;
  req_t q_data;

  chte_front u_front (
    .clk, .rst_n, .start, .busy,
    .in_action, .in_key_bytes, .in_key_length, .in_new_value,
    .q_valid, .q_data, .q_pop
  );

  chte_back u_back (
    .clk, .rst_n, .q_valid, .q_data, .q_pop,
    .out_valid, .out_status, .out_found_value, .out_entry_count
  );

endmodule

// ----- sv/chte_front.sv -----
module chte_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_action,
  input  logic [63:0]          in_key_bytes,
  input  logic [3:0]           in_key_length,
  input  logic [31:0]          in_new_value,
  output logic                 q_valid,
  output chte_pkg::req_t       q_data,
  input  logic                 q_pop
);
  import chte_pkg::*;

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_HASH = 2'b10
  } fstate_t;

  fstate_t      st_r, st_nxt;
  req_t         cur_r, cur_nxt;
  logic [3:0]   step_r, step_nxt;
  req_t         q_mem_r [QDepth];
  logic         q_wptr_r, q_rptr_r;
  logic [1:0]   q_cnt_r;
  logic         push;
  logic [3:0]   eff_len;

  assign busy    = (st_r != F_IDLE);
  assign q_valid = (q_cnt_r != 2'd0);
  assign q_data  = q_mem_r[q_rptr_r];
  assign eff_len = (cur_r.len > 4'(KeyBytes)) ? 4'(KeyBytes) : cur_r.len;
  assign push    = (st_r == F_HASH) && (step_r == eff_len) && (q_cnt_r != 2'(QDepth));

  always_comb begin
    st_nxt   = st_r;
    cur_nxt  = cur_r;
    step_nxt = step_r;
    unique case (st_r)
      F_IDLE: begin
        if (start) begin
          cur_nxt.action = in_action;
          cur_nxt.len    = in_key_length;
          cur_nxt.key    = in_key_bytes & key_mask(in_key_length);
          cur_nxt.value  = in_new_value;
          cur_nxt.hash   = '0;
          cur_nxt.bad    = (in_key_length > 4'(KeyBytes)) ||
                           ((in_key_length == 4'd0) &&
                            ((in_action == ACT_ADD) || (in_action == ACT_REPLACE)));
          step_nxt       = '0;
          st_nxt         = F_HASH;
        end
      end
      F_HASH: begin
        if (step_r != eff_len) begin
          cur_nxt.hash = (cur_r.hash << 5) + cur_r.hash
                         + {24'd0, cur_r.key[{step_r[2:0], 3'd0} +: 8]};
          step_nxt     = step_r + 4'd1;
        end else if (push) begin
          st_nxt = F_IDLE;
        end
      end
      default: st_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= F_IDLE;
      q_wptr_r <= 1'b0;
      q_rptr_r <= 1'b0;
      q_cnt_r  <= '0;
    end else begin
      st_r <= st_nxt;
      if (push) q_wptr_r <= ~q_wptr_r;
      if (q_pop) q_rptr_r <= ~q_rptr_r;
      q_cnt_r <= q_cnt_r + 2'(push) - 2'(q_pop);
    end
    cur_r  <= cur_nxt;
    step_r <= step_nxt;
    if (push) q_mem_r[q_wptr_r] <= cur_r;
  end

  assert property (@(posedge clk) disable iff (!rst_n) q_cnt_r <= 2'(QDepth))
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n) push |-> st_r == F_HASH)
    else $error("push outside hash");
  assert property (@(posedge clk) disable iff (!rst_n) (q_cnt_r == 2'd0) |-> !q_pop)
    else $error("pop of empty queue");

endmodule

// ----- sv/chte_back.sv -----
module chte_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  chte_pkg::req_t       q_data,
  output logic                 q_pop,
  output logic                 out_valid,
  output logic [1:0]           out_status,
  output logic [31:0]          out_found_value,
  output logic [6:0]           out_entry_count
);
  import chte_pkg::*;

  typedef enum logic [5:0] {
    B_IDLE = 6'b000001,
    B_HEAD = 6'b000010,
    B_RD   = 6'b000100,
    B_CMP  = 6'b001000,
    B_FLNK = 6'b010000,
    B_DONE = 6'b100000
  } bstate_t;

  bstate_t             st_r;
  req_t                req_r;
  logic [PtrW-1:0]     head_r [Buckets];
  logic [PtrW-1:0]     free_r, unused_r;
  logic [CntW-1:0]     cnt_r;
  logic [PtrW-1:0]     cur_r, prev_r;
  logic [IdxW:0]       steps_r;
  logic [1:0]          stat_r;
  logic [31:0]         fval_r;
  logic [63:0]         m_key [Entries];
  logic [3:0]          m_len [Entries];
  logic [31:0]         m_hash [Entries];
  logic [31:0]         m_data [Entries];
  logic [PtrW-1:0]     m_link [Entries];
  logic [63:0]         rd_key_r;
  logic [3:0]          rd_len_r;
  logic [31:0]         rd_hash_r, rd_data_r;
  logic [PtrW-1:0]     rd_link_r;
  logic [BktW-1:0]     bkt;
  logic                hit;

  assign bkt   = req_r.hash[BktW-1:0];
  assign hit   = (rd_hash_r == req_r.hash) && (rd_len_r == req_r.len) &&
                 (rd_key_r == req_r.key);
  assign q_pop = (st_r == B_IDLE) && q_valid;

  assign out_valid       = (st_r == B_DONE);
  assign out_status      = stat_r;
  assign out_found_value = fval_r;
  assign out_entry_count = cnt_r;

  always_ff @(posedge clk) begin
    if (st_r == B_RD) begin
      if (cur_r >= NullPtr || steps_r == (IdxW+1)'(Entries)) begin
        rd_link_r <= m_link[free_r[IdxW-1:0]];
      end else begin
        rd_key_r  <= m_key[cur_r[IdxW-1:0]];
        rd_len_r  <= m_len[cur_r[IdxW-1:0]];
        rd_hash_r <= m_hash[cur_r[IdxW-1:0]];
        rd_data_r <= m_data[cur_r[IdxW-1:0]];
        rd_link_r <= m_link[cur_r[IdxW-1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= B_IDLE;
      free_r   <= NullPtr;
      unused_r <= '0;
      cnt_r    <= '0;
      for (int i = 0; i < Buckets; i++) head_r[i] <= NullPtr;
    end else begin
      unique case (st_r)
        B_IDLE: begin
          if (q_valid) begin
            req_r <= q_data;
            st_r  <= B_HEAD;
          end
        end
        B_HEAD: begin
          fval_r  <= '0;
          stat_r  <= ST_OK;
          prev_r  <= NullPtr;
          steps_r <= '0;
          if (req_r.bad) begin
            stat_r <= ST_BAD;
            st_r   <= B_DONE;
          end else begin
            cur_r <= head_r[bkt];
            st_r  <= B_RD;
          end
        end
        B_RD: begin
          if (cur_r >= NullPtr || steps_r == (IdxW+1)'(Entries)) begin
            if (req_r.action == ACT_ADD) begin
              if (free_r != NullPtr) begin
                st_r <= B_FLNK;
              end else if (unused_r != NullPtr) begin
                m_key[unused_r[IdxW-1:0]]  <= req_r.key;
                m_len[unused_r[IdxW-1:0]]  <= req_r.len;
                m_hash[unused_r[IdxW-1:0]] <= req_r.hash;
                m_data[unused_r[IdxW-1:0]] <= req_r.value;
                m_link[unused_r[IdxW-1:0]] <= NullPtr;
                if (prev_r != NullPtr) m_link[prev_r[IdxW-1:0]] <= unused_r;
                else head_r[bkt] <= unused_r;
                unused_r <= unused_r + PtrW'(1);
                cnt_r    <= cnt_r + CntW'(1);
                st_r     <= B_DONE;
              end else begin
                stat_r <= ST_FULL;
                st_r   <= B_DONE;
              end
            end else begin
              stat_r <= ST_MISS;
              st_r   <= B_DONE;
            end
          end else begin
            st_r <= B_CMP;
          end
        end
        B_CMP: begin
          if (hit) begin
            st_r <= B_DONE;
            unique case (req_r.action)
              ACT_ADD:     stat_r <= ST_MISS;
              ACT_REPLACE: m_data[cur_r[IdxW-1:0]] <= req_r.value;
              ACT_LOOKUP:  fval_r <= rd_data_r;
              ACT_REMOVE: begin
                if (prev_r != NullPtr) m_link[prev_r[IdxW-1:0]] <= rd_link_r;
                else head_r[bkt] <= rd_link_r;
                m_link[cur_r[IdxW-1:0]] <= free_r;
                free_r <= cur_r;
                if (cnt_r != '0) cnt_r <= cnt_r - CntW'(1);
              end
              default: ;
            endcase
          end else begin
            prev_r  <= cur_r;
            cur_r   <= rd_link_r;
            steps_r <= steps_r + (IdxW+1)'(1);
            st_r    <= B_RD;
          end
        end
        B_FLNK: begin
          m_key[free_r[IdxW-1:0]]  <= req_r.key;
          m_len[free_r[IdxW-1:0]]  <= req_r.len;
          m_hash[free_r[IdxW-1:0]] <= req_r.hash;
          m_data[free_r[IdxW-1:0]] <= req_r.value;
          m_link[free_r[IdxW-1:0]] <= NullPtr;
          if (prev_r != NullPtr) m_link[prev_r[IdxW-1:0]] <= free_r;
          else head_r[bkt] <= free_r;
          free_r <= rd_link_r;
          cnt_r  <= cnt_r + CntW'(1);
          st_r   <= B_DONE;
        end
        B_DONE: begin
          st_r <= B_IDLE;
        end
        default: st_r <= B_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) out_valid |=> !out_valid)
    else $error("result held past one cycle");
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CntW'(Entries))
    else $error("entry count overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_BAD) |-> $past(st_r) == B_HEAD)
    else $error("bad argument after walk");

endmodule

// ----- test/tb_top.sv -----
module tb_top;
  import chte_pkg::*;

  localparam int NumEntries = 64;
  localparam int NumBuckets = 16;
  localparam logic [6:0] NoLink = 7'd64;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_action = '0;
  logic [63:0] in_key_bytes = '0;
  logic [3:0]  in_key_length = '0;
  logic [31:0] in_new_value = '0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [31:0] out_found_value;
  logic [6:0]  out_entry_count;

  chained_hash_table_engine_top dut (.*);

  always #5 clk = ~clk;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value;
    logic [6:0]  count;
  } reply_t;

  reply_t      pending_replies[$];
  int          errors = 0;
  int          burst_left = 0;

  logic [6:0]  bkt_head[NumBuckets];
  logic [63:0] ent_key[NumEntries];
  logic [3:0]  ent_len[NumEntries];
  logic [31:0] ent_hash[NumEntries];
  logic [31:0] ent_data[NumEntries];
  logic [6:0]  ent_link[NumEntries];
  logic [6:0]  free_list;
  logic [6:0]  fresh_next;
  logic [6:0]  held;
  logic [63:0] used_keys[$];

  function automatic logic [31:0] times33(logic [63:0] k, logic [3:0] n);
    logic [31:0] h;
    h = '0;
    for (int i = 0; i < n; i++) h = h * 32'd33 + 32'(k[8*i +: 8]);
    return h;
  endfunction

  function automatic reply_t table_apply(action_t act, logic [63:0] kin,
                                         logic [3:0] n, logic [31:0] v);
    reply_t r;
    logic [63:0] k;
    logic [31:0] h;
    logic [3:0] b;
    logic [6:0] cur, prev, e;
    bit found;
    r = '0;
    found = 0;
    k = '0;
    for (int i = 0; i < 8; i++) if (i < n) k[8*i +: 8] = kin[8*i +: 8];
    if (n > 4'd8 || (n == 0 && (act == ACT_ADD || act == ACT_REPLACE))) begin
      r.status = ST_BAD;
    end else begin
      h = times33(k, n);
      b = h[3:0];
      prev = NoLink;
      cur = bkt_head[b];
      for (int s = 0; s < NumEntries && cur < NoLink; s++) begin
        if (ent_hash[cur] == h && ent_len[cur] == n && ent_key[cur] == k) begin
          found = 1;
          break;
        end
        prev = cur;
        cur = ent_link[cur];
      end
      if (act == ACT_ADD) begin
        if (found) begin
          r.status = ST_MISS;
        end else begin
          if (free_list < NoLink) begin
            e = free_list;
            free_list = ent_link[e];
          end else if (fresh_next < NoLink) begin
            e = fresh_next;
            fresh_next++;
          end else begin
            e = NoLink;
          end
          if (e == NoLink) begin
            r.status = ST_FULL;
          end else begin
            ent_key[e] = k;
            ent_len[e] = n;
            ent_hash[e] = h;
            ent_data[e] = v;
            ent_link[e] = NoLink;
            if (prev < NoLink) ent_link[prev] = e;
            else bkt_head[b] = e;
            held++;
          end
        end
      end else if (!found) begin
        r.status = ST_MISS;
      end else if (act == ACT_REPLACE) begin
        ent_data[cur] = v;
      end else if (act == ACT_LOOKUP) begin
        r.value = ent_data[cur];
      end else begin
        if (prev < NoLink) ent_link[prev] = ent_link[cur];
        else bkt_head[b] = ent_link[cur];
        ent_link[cur] = free_list;
        free_list = cur;
        if (held > 0) held--;
      end
    end
    r.count = held;
    return r;
  endfunction

  task automatic send_request(action_t act, logic [63:0] k, logic [3:0] n,
                              logic [31:0] v);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    in_action <= act;
    in_key_bytes <= k;
    in_key_length <= n;
    in_new_value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_replies.push_back(table_apply(act, k, n, v));
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_valid) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected result status=%0d value=%h count=%0d", $time,
                 out_status, out_found_value, out_entry_count);
        errors++;
      end else begin
        want = pending_replies.pop_front();
        if (want.status != out_status)
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
        if (want.value != out_found_value)
          $display("%0t: value expected %h actual %h", $time, want.value, out_found_value);
        if (want.count != out_entry_count)
          $display("%0t: count expected %0d actual %0d", $time, want.count,
                   out_entry_count);
        if (want != {out_status, out_found_value, out_entry_count}) errors++;
      end
    end
  end

  function automatic logic [63:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] pick_key();
    if (used_keys.size() == 0 || $urandom_range(0, 3) == 0) return rand_key();
    return used_keys[$urandom_range(0, used_keys.size() - 1)];
  endfunction

  task automatic test_bad_lengths();
    send_request(ACT_ADD, 64'hffff_ffff_ffff_ffff, 4'd0, 32'h1234);
    send_request(ACT_REPLACE, 64'h0, 4'd0, 32'hffff_ffff);
    send_request(ACT_LOOKUP, 64'h0, 4'd0, 32'h0);
    send_request(ACT_REMOVE, 64'h55, 4'd0, 32'h0);
    send_request(ACT_ADD, 64'h1, 4'd9, 32'h1);
    send_request(ACT_LOOKUP, 64'h1, 4'd15, 32'h0);
    send_request(ACT_REMOVE, 64'h1, 4'd12, 32'h0);
  endtask

  task automatic test_basic_ops();
    send_request(ACT_ADD, 64'hffff_ffff_ffff_ffff, 4'd8, 32'hffff_ffff);
    send_request(ACT_ADD, 64'hffff_ffff_ffff_ffff, 4'd8, 32'h0);
    send_request(ACT_LOOKUP, 64'hffff_ffff_ffff_ffff, 4'd8, 32'h0);
    send_request(ACT_ADD, 64'hffff_ffff_ffff_ff00, 4'd1, 32'h0);
    send_request(ACT_LOOKUP, 64'h0, 4'd1, 32'h0);
    send_request(ACT_REPLACE, 64'h0, 4'd1, 32'haaaa_5555);
    send_request(ACT_LOOKUP, 64'hab00, 4'd1, 32'h0);
    send_request(ACT_REPLACE, 64'h77, 4'd2, 32'h1);
    send_request(ACT_REMOVE, 64'h0, 4'd1, 32'h0);
    send_request(ACT_REMOVE, 64'h0, 4'd1, 32'h0);
    send_request(ACT_LOOKUP, 64'h0, 4'd1, 32'h0);
    send_request(ACT_ADD, 64'h0102, 4'd2, 32'h5);
    send_request(ACT_ADD, 64'h1102, 4'd2, 32'h6);
    send_request(ACT_REMOVE, 64'h0102, 4'd2, 32'h0);
    send_request(ACT_LOOKUP, 64'h1102, 4'd2, 32'h0);
  endtask

  task automatic test_pool_full();
    logic [63:0] k;
    for (int i = 0; i < 66; i++) begin
      k = rand_key();
      used_keys.push_back(k);
      send_request(ACT_ADD, k, 4'($urandom_range(1, 8)), $urandom());
    end
    for (int i = 0; i < 40; i++) send_request(ACT_REMOVE, pick_key(),
                                              4'($urandom_range(1, 8)), 32'd0);
  endtask

  task automatic test_random_mix();
    logic [3:0] n;
    for (int i = 0; i < 720; i++) begin
      n = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(0, 15))
                                       : 4'($urandom_range(1, 3));
      if ($urandom_range(0, 1)) used_keys.push_back(rand_key());
      if (used_keys.size() > 40) used_keys.pop_front();
      send_request(action_t'($urandom_range(0, 3)), pick_key(), n, $urandom());
    end
  endtask

  initial begin
    for (int i = 0; i < NumBuckets; i++) bkt_head[i] = NoLink;
    for (int i = 0; i < NumEntries; i++) begin
      ent_key[i] = '0; ent_len[i] = '0; ent_hash[i] = '0;
      ent_data[i] = '0; ent_link[i] = '0;
    end
    free_list = NoLink;
    fresh_next = '0;
    held = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_bad_lengths();
    test_basic_ops();
    test_pool_full();
    test_random_mix();
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #10000000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ----- chained_hash_table_engine_top.f -----
sv/chte_pkg.sv
sv/chte_front.sv
sv/chte_back.sv
sv/chained_hash_table_engine_top.sv
test/tb_top.sv
